### rtl/phe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phe_pkg: shared types and constants of the prefix rolling hash engine
// Field widths, operation and status codes, the two prime moduli with their
// Barrett reciprocals, and the residue pair stored in the hash memories.
// ----------------------------------------------------------------------------
package phe_pkg;

    localparam int unsigned MAX_LENGTH_DEF = 1024;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned SYM_W      = 31;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned HASH_W     = 30;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 30;
    localparam int unsigned MU_W       = 31;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_B = 1'd1;

    localparam logic [HASH_W-1:0] BASE_A_RST = 30'd131;
    localparam logic [HASH_W-1:0] BASE_B_RST = 30'd137;

    localparam logic [HASH_W-1:0] PRIME_A = 30'd1000000007;
    localparam logic [HASH_W-1:0] PRIME_B = 30'd1000000009;

    // floor(2^60 / m) for Barrett reduction of a 60-bit product
    localparam logic [MU_W-1:0] MU_A = MU_W'((64'd1 << 60) / 64'(PRIME_A));
    localparam logic [MU_W-1:0] MU_B = MU_W'((64'd1 << 60) / 64'(PRIME_B));

    typedef struct packed {
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] a;
    } t_pair;

    localparam t_pair PAIR_ZERO = '{b: 30'd0, a: 30'd0};
    localparam t_pair PAIR_ONE  = '{b: 30'd1, a: 30'd1};

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_cmd;

endpackage
`default_nettype wire

### rtl/phe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phe_in_if: request channel of the prefix rolling hash engine
// Valid/ready handshake carrying one operation with its symbol and range.
// ----------------------------------------------------------------------------
interface phe_in_if;
    import phe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  start_index;
    logic [IDX_W-1:0]  end_index;

    modport source (output valid, output op, output symbol, output start_index,
                    output end_index, input ready);
    modport sink   (input valid, input op, input symbol, input start_index,
                    input end_index, output ready);
endinterface
`default_nettype wire

### rtl/phe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phe_out_if: result channel of the prefix rolling hash engine
// Valid/ready handshake carrying the residue pair, length and status.
// ----------------------------------------------------------------------------
interface phe_out_if;
    import phe_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic [LEN_W-1:0]  length;
    logic [ST_W-1:0]   status;

    modport source (output valid, output hash_a, output hash_b, output length,
                    output status, input ready);
    modport sink   (input valid, input hash_a, input hash_b, input length,
                    input status, output ready);
endinterface
`default_nettype wire

### rtl/phe_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phe_modmul: pipelined modular multiplier
// Five-stage Barrett reduction of a 30x30-bit product by a 30-bit modulus.
// ----------------------------------------------------------------------------
module phe_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [phe_pkg::HASH_W-1:0] i_x,
    input  logic [phe_pkg::HASH_W-1:0] i_y,
    input  logic [phe_pkg::HASH_W-1:0] i_mod,
    input  logic [phe_pkg::MU_W-1:0]   i_mu,
    output logic                       o_valid,
    output logic [phe_pkg::HASH_W-1:0] o_res
);
    import phe_pkg::*;

    localparam int unsigned PROD_W = 2 * HASH_W;
    localparam int unsigned Q1_W   = HASH_W + 1;
    localparam int unsigned Q2_W   = Q1_W + MU_W;
    localparam int unsigned R_W    = HASH_W + 2;
    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [PROD_W-1:0] r_prod;
    logic [Q1_W-1:0]   r_q;
    logic [R_W-1:0]    r_plo2;
    logic [R_W-1:0]    r_qm;
    logic [R_W-1:0]    r_plo3;
    logic [R_W-1:0]    r_diff;
    logic [HASH_W-1:0] r_res;

    logic [PROD_W-1:0] w_prod;
    logic [Q2_W-1:0]   w_q2;
    logic [R_W-1:0]    w_qm;
    logic [R_W-1:0]    w_m1;
    logic [R_W-1:0]    w_m2;
    logic [R_W-1:0]    w_sel;

    assign w_prod = PROD_W'(i_x) * PROD_W'(i_y);
    assign w_q2   = Q2_W'(r_prod[PROD_W-1:HASH_W-1]) * Q2_W'(i_mu);
    // only the low bits of q*m matter: the remainder stays below 3m
    assign w_qm   = R_W'(r_q) * R_W'(i_mod);
    assign w_m1   = r_diff - R_W'(i_mod);
    assign w_m2   = r_diff - R_W'({i_mod, 1'b0});

    always_comb begin
        if (r_diff >= R_W'({i_mod, 1'b0})) begin
            w_sel = w_m2;
        end else if (r_diff >= R_W'(i_mod)) begin
            w_sel = w_m1;
        end else begin
            w_sel = r_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_q    <= Q1_W'(w_q2 >> (HASH_W + 1));
        r_plo2 <= r_prod[R_W-1:0];
        r_qm   <= w_qm;
        r_plo3 <= r_plo2;
        r_diff <= r_plo3 - r_qm;
        r_res  <= HASH_W'(w_sel);
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_res   = r_res;

`ifndef ASSERT_OFF
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res < i_mod))
        else $error("modular product not fully reduced");
`endif

endmodule
`default_nettype wire

### rtl/phe_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phe_store: prefix and power memories
// Prefix memory with two read ports, power memory with one, one write port
// each, registered read data. Entry zero must never be written; the block
// does not enforce it. Entry zero reads as zero prefix and unit power.
// ----------------------------------------------------------------------------
module phe_store #(
    parameter  int unsigned DEPTH  = phe_pkg::MAX_LENGTH_DEF + 1,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  phe_pkg::t_store_cmd i_cmd,
    input  logic [ADDR_W-1:0]   i_rd_addr0,
    input  logic [ADDR_W-1:0]   i_rd_addr1,
    input  logic [ADDR_W-1:0]   i_pw_addr,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  phe_pkg::t_pair      i_wr_prefix,
    input  phe_pkg::t_pair      i_wr_power,
    output phe_pkg::t_pair      o_prefix0,
    output phe_pkg::t_pair      o_prefix1,
    output phe_pkg::t_pair      o_power
);
    import phe_pkg::*;

    t_pair r_prefix_mem [DEPTH];
    t_pair r_power_mem  [DEPTH];

    t_pair r_rd_p0;
    t_pair r_rd_p1;
    t_pair r_rd_pw;
    logic  r_zero0;
    logic  r_zero1;
    logic  r_zerow;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_prefix_mem[i_wr_addr] <= i_wr_prefix;
            r_power_mem[i_wr_addr]  <= i_wr_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_p0 <= r_prefix_mem[i_rd_addr0];
            r_rd_p1 <= r_prefix_mem[i_rd_addr1];
            r_rd_pw <= r_power_mem[i_pw_addr];
            r_zero0 <= (i_rd_addr0 == '0);
            r_zero1 <= (i_rd_addr1 == '0);
            r_zerow <= (i_pw_addr == '0);
        end
    end

    assign o_prefix0 = r_zero0 ? PAIR_ZERO : r_rd_p0;
    assign o_prefix1 = r_zero1 ? PAIR_ZERO : r_rd_p1;
    assign o_power   = r_zerow ? PAIR_ONE  : r_rd_pw;

`ifndef ASSERT_OFF
    a_no_write_zero: assert property (@(posedge i_clk)
        i_cmd.wr_en |-> (i_wr_addr != '0))
        else $error("write to entry zero");
    a_no_rd_wr_overlap: assert property (@(posedge i_clk)
        !(i_cmd.wr_en && i_cmd.rd_en))
        else $error("read and write in the same cycle");
`endif

endmodule
`default_nettype wire

### rtl/prefix_rolling_hash_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_rolling_hash_engine: double-modulus prefix rolling hash
// Append, pop and substring query over prefix hashes kept in memory.
// ----------------------------------------------------------------------------
// Append and query: the request passes the registered memory read, the
//   five-stage Barrett multiplier pipeline and the result register; the next
//   request is taken only once the result has been loaded for output.
// Pop and error results skip the multiplier; here too one request at a time.
// Reset (synchronous, active low): empty string, bases 131 and 137, no clearing
//   pass; entry zero reads as zero in the prefix memory, one in the power memory.
// ----------------------------------------------------------------------------
module prefix_rolling_hash_engine #(
    parameter int unsigned MAX_LENGTH = phe_pkg::MAX_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [phe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [phe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    phe_in_if.sink                         i_in,
    phe_out_if.source                      o_out
);
    import phe_pkg::*;

    localparam int unsigned DEPTH = MAX_LENGTH + 1;
    localparam int unsigned CNT_W = $clog2(DEPTH);
    localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    function automatic logic [HASH_W-1:0] f_mod_add(input logic [HASH_W-1:0] x,
                                                    input logic [HASH_W-1:0] y,
                                                    input logic [HASH_W-1:0] m);
        logic [HASH_W:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        return (sum >= {1'b0, m}) ? HASH_W'(sum - {1'b0, m}) : HASH_W'(sum);
    endfunction

    function automatic logic [HASH_W-1:0] f_mod_sub(input logic [HASH_W-1:0] x,
                                                    input logic [HASH_W-1:0] y,
                                                    input logic [HASH_W-1:0] m);
        logic [HASH_W:0] wrap;
        wrap = {1'b0, x} + {1'b0, m} - {1'b0, y};
        return (x >= y) ? (x - y) : HASH_W'(wrap);
    endfunction

    // symbol is below 2^31, so below three times either prime
    function automatic logic [HASH_W-1:0] f_sym_mod(input logic [SYM_W-1:0]  s,
                                                    input logic [HASH_W-1:0] m);
        logic [SYM_W-1:0] m1;
        logic [SYM_W-1:0] m2;
        m1 = SYM_W'(m);
        m2 = SYM_W'({m, 1'b0});
        if (s >= m2) begin
            return HASH_W'(s - m2);
        end else if (s >= m1) begin
            return HASH_W'(s - m1);
        end
        return HASH_W'(s);
    endfunction

    function automatic logic [HASH_W-1:0] f_base_mod(input logic [HASH_W-1:0] x,
                                                     input logic [HASH_W-1:0] m);
        return (x >= m) ? (x - m) : x;
    endfunction

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OP_W-1:0]   r_op;
    logic [ST_W-1:0]   r_status;
    logic [LEN_W-1:0]  r_len;
    logic [HASH_W-1:0] r_sym_a, r_sym_b;
    logic [HASH_W-1:0] r_ba, r_bb;
    logic [HASH_W-1:0] r_base_a, r_base_b;
    logic [HASH_W-1:0] r_mm_pa, r_mm_pb, r_mm_wa, r_mm_wb;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_ha, r_out_hb;
    logic [LEN_W-1:0]  r_out_len;
    logic [ST_W-1:0]   r_out_st;

    logic              w_in_fire;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_mm_start;
    logic              w_mm_valid;
    logic              w_append_ok;
    logic [CMP_W-1:0]  w_cnt, w_s, w_e, w_e1, w_len;
    logic [CNT_W-1:0]  w_addr0, w_addr1, w_addrw, w_wr_addr;
    logic [ST_W-1:0]   w_status;
    logic              w_full, w_empty, w_bad;
    logic [HASH_W-1:0] w_fin_ha, w_fin_hb;
    logic [LEN_W-1:0]  w_fin_len;
    t_store_cmd        w_cmd;
    t_pair             w_p0, w_p1, w_pw;
    t_pair             w_wr_prefix, w_wr_power;
    logic              w_v_pa, w_v_pb, w_v_wa, w_v_wb;
    logic [HASH_W-1:0] w_res_pa, w_res_pb, w_res_wa, w_res_wb;
    logic [HASH_W-1:0] w_x_a, w_x_b, w_y_a, w_y_b;

    // one item at a time: the write-back ends before the next read can start
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = (r_state == S_FINISH) && w_out_free;

    // ---------------- request decode ----------------
    assign w_cnt = CMP_W'(r_count);
    assign w_s   = CMP_W'(i_in.start_index);
    assign w_e   = CMP_W'(i_in.end_index);
    assign w_e1  = w_e + CMP_W'(1);
    assign w_len = w_e - w_s + CMP_W'(1);

    assign w_full  = (r_count >= CNT_W'(MAX_LENGTH));
    assign w_empty = (r_count == '0);
    assign w_bad   = (w_s > w_e) || (w_e >= w_cnt);

    always_comb begin
        w_addr0  = r_count;
        w_addr1  = w_s[CNT_W-1:0];
        w_addrw  = r_count;
        w_status = ST_OK;
        case (i_in.op)
            OP_APPEND: begin
                w_status = w_full ? ST_FULL : ST_OK;
            end
            OP_POP: begin
                w_addr0  = r_count - CNT_W'(1);
                w_status = w_empty ? ST_EMPTY : ST_OK;
            end
            OP_QUERY: begin
                w_addr0  = w_e1[CNT_W-1:0];
                w_addrw  = w_len[CNT_W-1:0];
                w_status = w_bad ? ST_RANGE : ST_OK;
            end
            default: begin
            end
        endcase
    end

    // ---------------- memories ----------------
    assign w_append_ok   = (r_op == OP_APPEND) && (r_status == ST_OK);
    assign w_cmd.rd_en   = w_in_fire;
    assign w_cmd.wr_en   = w_out_load && w_append_ok;
    assign w_wr_addr     = r_count + CNT_W'(1);
    assign w_wr_prefix.a = w_fin_ha;
    assign w_wr_prefix.b = w_fin_hb;
    assign w_wr_power.a  = r_mm_wa;
    assign w_wr_power.b  = r_mm_wb;

    phe_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_rd_addr0  (w_addr0),
        .i_rd_addr1  (w_addr1),
        .i_pw_addr   (w_addrw),
        .i_wr_addr   (w_wr_addr),
        .i_wr_prefix (w_wr_prefix),
        .i_wr_power  (w_wr_power),
        .o_prefix0   (w_p0),
        .o_prefix1   (w_p1),
        .o_power     (w_pw)
    );

    // ---------------- modular multipliers ----------------
    // append: prefix[n]*base and power[n]*base; query: prefix[s]*power[len]
    assign w_mm_start = (r_state == S_LOAD) && (r_status == ST_OK) &&
                        ((r_op == OP_APPEND) || (r_op == OP_QUERY));
    assign w_x_a = (r_op == OP_QUERY) ? w_p1.a : w_p0.a;
    assign w_x_b = (r_op == OP_QUERY) ? w_p1.b : w_p0.b;
    assign w_y_a = (r_op == OP_QUERY) ? w_pw.a : r_ba;
    assign w_y_b = (r_op == OP_QUERY) ? w_pw.b : r_bb;

    phe_modmul u_mm_pa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_mm_start),
        .i_x(w_x_a), .i_y(w_y_a), .i_mod(PRIME_A), .i_mu(MU_A),
        .o_valid(w_v_pa), .o_res(w_res_pa)
    );

    phe_modmul u_mm_pb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_mm_start),
        .i_x(w_x_b), .i_y(w_y_b), .i_mod(PRIME_B), .i_mu(MU_B),
        .o_valid(w_v_pb), .o_res(w_res_pb)
    );

    phe_modmul u_mm_wa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_mm_start),
        .i_x(w_pw.a), .i_y(r_ba), .i_mod(PRIME_A), .i_mu(MU_A),
        .o_valid(w_v_wa), .o_res(w_res_wa)
    );

    phe_modmul u_mm_wb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_mm_start),
        .i_x(w_pw.b), .i_y(r_bb), .i_mod(PRIME_B), .i_mu(MU_B),
        .o_valid(w_v_wb), .o_res(w_res_wb)
    );

    assign w_mm_valid = w_v_pa && w_v_pb && w_v_wa && w_v_wb;

    // ---------------- result selection ----------------
    always_comb begin
        w_fin_ha  = '0;
        w_fin_hb  = '0;
        w_fin_len = '0;
        n_count   = r_count;
        case (r_op)
            OP_APPEND: begin
                if (r_status == ST_OK) begin
                    w_fin_ha  = f_mod_add(r_mm_pa, r_sym_a, PRIME_A);
                    w_fin_hb  = f_mod_add(r_mm_pb, r_sym_b, PRIME_B);
                    w_fin_len = LEN_W'(w_wr_addr);
                    n_count   = w_wr_addr;
                end else begin
                    w_fin_ha  = w_p0.a;
                    w_fin_hb  = w_p0.b;
                    w_fin_len = LEN_W'(r_count);
                end
            end
            OP_POP: begin
                if (r_status == ST_OK) begin
                    w_fin_ha  = w_p0.a;
                    w_fin_hb  = w_p0.b;
                    w_fin_len = LEN_W'(r_count - CNT_W'(1));
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_QUERY: begin
                if (r_status == ST_OK) begin
                    w_fin_ha  = f_mod_sub(w_p0.a, r_mm_pa, PRIME_A);
                    w_fin_hb  = f_mod_sub(w_p0.b, r_mm_pb, PRIME_B);
                    w_fin_len = r_len;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                // drop the undefined op code without a result
                if (w_in_fire && ((i_in.op == OP_APPEND) || (i_in.op == OP_POP) ||
                                  (i_in.op == OP_QUERY))) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = w_mm_start ? S_WAIT : S_FINISH;
            end
            S_WAIT: begin
                if (w_mm_valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_base_a    <= BASE_A_RST;
            r_base_b    <= BASE_B_RST;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_A: r_base_a <= i_cfg_data;
                    CFG_BASE_B: r_base_b <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op     <= i_in.op;
            r_status <= w_status;
            r_len    <= LEN_W'(w_len);
            r_sym_a  <= f_sym_mod(i_in.symbol, PRIME_A);
            r_sym_b  <= f_sym_mod(i_in.symbol, PRIME_B);
            r_ba     <= f_base_mod(r_base_a, PRIME_A);
            r_bb     <= f_base_mod(r_base_b, PRIME_B);
        end
        if ((r_state == S_WAIT) && w_mm_valid) begin
            r_mm_pa <= w_res_pa;
            r_mm_pb <= w_res_pb;
            r_mm_wa <= w_res_wa;
            r_mm_wb <= w_res_wb;
        end
        if (w_out_load) begin
            r_out_ha  <= w_fin_ha;
            r_out_hb  <= w_fin_hb;
            r_out_len <= w_fin_len;
            r_out_st  <= r_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.hash_a = r_out_ha;
    assign o_out.hash_b = r_out_hb;
    assign o_out.length = r_out_len;
    assign o_out.status = r_out_st;

`ifndef ASSERT_OFF
    a_count_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(w_out_load))
        else $error("symbol count changed without a result");
    a_write_only_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> ((r_state == S_FINISH) && (r_op == OP_APPEND) &&
                         (r_status == ST_OK)))
        else $error("store written outside a successful append");
    a_mm_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_valid |-> (r_state == S_WAIT))
        else $error("multiplier result outside the wait state");
`endif

endmodule
`default_nettype wire

### verif/prefix_rolling_hash_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_rolling_hash_engine_tb: self-checking bench of the rolling hash engine
// Walks a short table of appends, pops and queries, then runs random sequences
// over several base settings up to a full store, with bursty requests and a
// stalling result side. Every result is checked against an in-bench predictor or a table entry.
// ----------------------------------------------------------------------------
module prefix_rolling_hash_engine_tb;
    import phe_pkg::*;

    localparam int unsigned DEPTH      = MAX_LENGTH_DEF;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned SETTLE     = 12;

    localparam logic [OP_W-1:0]  OP_UNDEF = 2'd3;
    localparam logic [SYM_W-1:0] SYM_MAX  = {SYM_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
    } t_hash_req;

    typedef struct packed {
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
        logic [LEN_W-1:0]  length;
        logic [ST_W-1:0]   status;
    } t_hash_res;

    typedef struct {
        t_hash_req req;
        bit        typed;
        t_hash_res res;
    } t_dir_row;

    typedef enum int unsigned { MIX_NORMAL, MIX_FILL } t_mix;
    typedef enum int unsigned { RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY } t_rx_mode;

    localparam t_hash_res RES_NONE    = '0;
    localparam t_hash_res RES_EMPTY   = '{hash_a: '0, hash_b: '0, length: '0, status: ST_EMPTY};
    localparam t_hash_res RES_RANGE   = '{hash_a: '0, hash_b: '0, length: '0, status: ST_RANGE};
    localparam t_hash_res RES_VOID_OK = '{hash_a: '0, hash_b: '0, length: '0, status: ST_OK};
    localparam t_hash_res RES_ONE_OK  = '{hash_a: '0, hash_b: '0, length: 11'd1, status: ST_OK};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    phe_in_if  req_if ();
    phe_out_if res_if ();

    prefix_rolling_hash_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // predictor state
    logic [HASH_W-1:0] pfx_a [0:DEPTH];
    logic [HASH_W-1:0] pfx_b [0:DEPTH];
    logic [HASH_W-1:0] pow_a [0:DEPTH];
    logic [HASH_W-1:0] pow_b [0:DEPTH];
    int unsigned       sym_cnt;
    logic [HASH_W-1:0] base_a;
    logic [HASH_W-1:0] base_b;

    t_hash_res   exp_hash_q [$];
    t_dir_row    dir_q [$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 0;
    bit          drv_typed    = 1'b0;
    t_hash_res   drv_typed_res;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [HASH_W-1:0] mul_mod(input logic [HASH_W-1:0] x, y, m);
        return HASH_W'((64'(x) * 64'(y)) % 64'(m));
    endfunction

    function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] x, y, m);
        return HASH_W'((64'(x) + 64'(y)) % 64'(m));
    endfunction

    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] x, y, m);
        return HASH_W'((64'(x) + 64'(m) - 64'(y)) % 64'(m));
    endfunction

    // Work out the result of one request and advance the stored string.
    task automatic hash_predict(input t_hash_req rq, output bit has_res, output t_hash_res rs);
        logic [HASH_W-1:0] ba, bb;
        int unsigned n, s, e, len;
        n       = sym_cnt;
        s       = rq.start_index;
        e       = rq.end_index;
        has_res = 1'b1;
        rs      = RES_NONE;
        case (rq.op)
            OP_APPEND: begin
                if (n >= DEPTH) begin
                    rs = '{hash_a: pfx_a[n], hash_b: pfx_b[n], length: LEN_W'(n),
                           status: ST_FULL};
                end else begin
                    ba = HASH_W'(64'(base_a) % 64'(PRIME_A));
                    bb = HASH_W'(64'(base_b) % 64'(PRIME_B));
                    pfx_a[n+1] = add_mod(mul_mod(pfx_a[n], ba, PRIME_A),
                                         HASH_W'(64'(rq.symbol) % 64'(PRIME_A)), PRIME_A);
                    pfx_b[n+1] = add_mod(mul_mod(pfx_b[n], bb, PRIME_B),
                                         HASH_W'(64'(rq.symbol) % 64'(PRIME_B)), PRIME_B);
                    pow_a[n+1] = mul_mod(pow_a[n], ba, PRIME_A);
                    pow_b[n+1] = mul_mod(pow_b[n], bb, PRIME_B);
                    sym_cnt    = n + 1;
                    rs = '{hash_a: pfx_a[n+1], hash_b: pfx_b[n+1], length: LEN_W'(n + 1),
                           status: ST_OK};
                end
            end
            OP_POP: begin
                if (n == 0) begin
                    rs = RES_EMPTY;
                end else begin
                    sym_cnt = n - 1;
                    rs = '{hash_a: pfx_a[n-1], hash_b: pfx_b[n-1], length: LEN_W'(n - 1),
                           status: ST_OK};
                end
            end
            OP_QUERY: begin
                if (s > e || e >= n) begin
                    rs = RES_RANGE;
                end else begin
                    len = e - s + 1;
                    rs.hash_a = sub_mod(pfx_a[e+1], mul_mod(pfx_a[s], pow_a[len], PRIME_A),
                                        PRIME_A);
                    rs.hash_b = sub_mod(pfx_b[e+1], mul_mod(pfx_b[s], pow_b[len], PRIME_B),
                                        PRIME_B);
                    rs.length = LEN_W'(len);
                    rs.status = ST_OK;
                end
            end
            default: has_res = 1'b0;
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned want, got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    function automatic t_dir_row row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                     input int unsigned s, e, input bit typed,
                                     input t_hash_res res);
        t_dir_row r;
        r.req   = '{op: op, symbol: sym, start_index: IDX_W'(s), end_index: IDX_W'(e)};
        r.typed = typed;
        r.res   = res;
        return r;
    endfunction

    // append one row to the end of the directed table
    task automatic add_row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input int unsigned s, e, input bit typed, input t_hash_res res);
        dir_q.insert(dir_q.size(), row(op, sym, s, e, typed, res));
    endtask

    function automatic logic [SYM_W-1:0] rand_symbol();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SYM_MAX;
            2:       return SYM_W'(PRIME_A);
            3:       return SYM_W'(PRIME_B);
            default: return SYM_W'($urandom);
        endcase
    endfunction

    function automatic t_hash_req make_req(input t_mix mix);
        t_hash_req   rq;
        int unsigned pick, n, s, e;
        n  = sym_cnt;
        rq = '{op: OP_APPEND, symbol: rand_symbol(), start_index: IDX_W'($urandom),
               end_index: IDX_W'($urandom)};
        pick = $urandom_range(0, 99);
        if (mix == MIX_NORMAL) begin
            rq.op = (pick < 45) ? OP_APPEND : (pick < 80) ? OP_QUERY :
                    (pick < 95) ? OP_POP : OP_UNDEF;
        end else if (n >= DEPTH) begin
            rq.op = (pick < 50) ? OP_APPEND : (pick < 90) ? OP_QUERY :
                    (pick < 95) ? OP_POP : OP_UNDEF;
        end else begin
            rq.op = (pick < 90) ? OP_APPEND : (pick < 97) ? OP_QUERY :
                    (pick < 99) ? OP_POP : OP_UNDEF;
        end
        if (rq.op == OP_QUERY) begin
            pick = $urandom_range(0, 99);
            if (n > 0 && pick < 15) begin
                rq.start_index = '0;
                rq.end_index   = IDX_W'(n - 1);
            end else if (n > 0 && pick < 80) begin
                e = $urandom_range(0, n - 1);
                s = $urandom_range(0, e);
                rq.start_index = IDX_W'(s);
                rq.end_index   = IDX_W'(e);
            end else if (n < DEPTH && pick < 88) begin
                // end runs past the string
                e = $urandom_range(n, DEPTH - 1);
                s = $urandom_range(0, e);
                rq.start_index = IDX_W'(s);
                rq.end_index   = IDX_W'(e);
            end else if (pick < 94) begin
                e = $urandom_range(0, DEPTH - 2);
                s = $urandom_range(e + 1, DEPTH - 1);
                rq.start_index = IDX_W'(s);
                rq.end_index   = IDX_W'(e);
            end
        end
        return rq;
    endfunction

    // Called at a falling edge: between bursts, may drop valid for a gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_req(input t_hash_req rq);
        req_if.op          = rq.op;
        req_if.symbol      = rq.symbol;
        req_if.start_index = rq.start_index;
        req_if.end_index   = rq.end_index;
        req_if.valid       = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic run_items(input t_mix mix, input int unsigned count);
        repeat (count) begin
            @(negedge i_clk);
            pace_sender();
            drv_typed = 1'b0;
            send_req(make_req(mix));
        end
    endtask

    // Hold requests until every result is back, then let the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (exp_hash_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_bases(input logic [CFG_DATA_W-1:0] a, b);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_BASE_A;
        i_cfg_data  = a;
        @(negedge i_clk);
        i_cfg_index = CFG_BASE_B;
        i_cfg_data  = b;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // result side: stall on its own pattern, changing style every segment
    t_rx_mode    rx_mode   = RX_FREE;
    int unsigned seg_left  = 0;
    int unsigned stall_left = 0;

    always @(negedge i_clk) begin
        if (seg_left == 0) begin
            seg_left = $urandom_range(20, 200);
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
        end
        seg_left--;
        case (rx_mode)
            RX_FREE:   res_if.ready = 1'b1;
            RX_COIN:   res_if.ready = 1'($urandom_range(0, 1));
            RX_SPARSE: res_if.ready = ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    res_if.ready = 1'b0;
                end else begin
                    res_if.ready = 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 24);
                end
            end
        endcase
    end

    // transfer monitor and scoreboard
    always @(posedge i_clk) begin : monitor
        bit        got;
        t_hash_res pred;
        t_hash_res want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BASE_A) base_a = i_cfg_data;
                else if (i_cfg_index == CFG_BASE_B) base_b = i_cfg_data;
            end
            if (req_if.valid && req_if.ready) begin
                hash_predict('{op: req_if.op, symbol: req_if.symbol,
                               start_index: req_if.start_index,
                               end_index: req_if.end_index}, got, pred);
                if (got) exp_hash_q.insert(exp_hash_q.size(),
                                           drv_typed ? drv_typed_res : pred);
            end
            if (res_if.valid && res_if.ready) begin
                if (exp_hash_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d",
                             $time, res_if.hash_a, res_if.hash_b, res_if.length,
                             res_if.status);
                    mismatch_cnt++;
                end else begin
                    want = exp_hash_q.pop_front();
                    check_field("hash_a", want.hash_a, res_if.hash_a);
                    check_field("hash_b", want.hash_b, res_if.hash_b);
                    check_field("length", want.length, res_if.length);
                    check_field("status", want.status, res_if.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("prefix_rolling_hash_engine test failed");
            $finish;
        end
    end

    initial begin : main
        req_if.valid       = 1'b0;
        req_if.op          = OP_APPEND;
        req_if.symbol      = '0;
        req_if.start_index = '0;
        req_if.end_index   = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_BASE_A;
        i_cfg_data         = '0;
        i_rst_n            = 1'b0;
        drv_typed_res      = RES_NONE;

        for (int i = 0; i <= DEPTH; i++) begin
            pfx_a[i] = '0;
            pfx_b[i] = '0;
            pow_a[i] = '0;
            pow_b[i] = '0;
        end
        pow_a[0] = 30'd1;
        pow_b[0] = 30'd1;
        sym_cnt  = 0;
        base_a   = BASE_A_RST;
        base_b   = BASE_B_RST;

        add_row(OP_POP,    '0,                 0,    0,    1'b1, RES_EMPTY);
        add_row(OP_QUERY,  '0,                 0,    0,    1'b1, RES_RANGE);
        add_row(OP_APPEND, '0,                 0,    0,    1'b1, RES_ONE_OK);
        add_row(OP_APPEND, SYM_MAX,            1023, 1023, 1'b0, RES_NONE);
        add_row(OP_APPEND, SYM_W'(PRIME_A),    0,    0,    1'b0, RES_NONE);
        add_row(OP_APPEND, SYM_W'(PRIME_B),    0,    0,    1'b0, RES_NONE);
        add_row(OP_APPEND, 31'd1,              0,    0,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 0,    4,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 2,    2,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 3,    1,    1'b1, RES_RANGE);
        add_row(OP_QUERY,  '0,                 0,    5,    1'b1, RES_RANGE);
        add_row(OP_QUERY,  SYM_MAX,            1023, 1023, 1'b1, RES_RANGE);
        add_row(OP_QUERY,  '0,                 0,    1023, 1'b1, RES_RANGE);
        // undefined op: no result, no change
        add_row(OP_UNDEF,  SYM_MAX,            1023, 1023, 1'b0, RES_NONE);
        add_row(OP_POP,    '0,                 0,    0,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 0,    3,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 1,    3,    1'b0, RES_NONE);
        add_row(OP_POP,    SYM_MAX,            1023, 1023, 1'b0, RES_NONE);
        add_row(OP_POP,    '0,                 0,    0,    1'b0, RES_NONE);
        add_row(OP_POP,    '0,                 0,    0,    1'b0, RES_NONE);
        add_row(OP_POP,    '0,                 0,    0,    1'b1, RES_VOID_OK);
        add_row(OP_POP,    '0,                 0,    0,    1'b1, RES_EMPTY);
        add_row(OP_APPEND, 31'h5555_5555,      0,    0,    1'b0, RES_NONE);
        add_row(OP_APPEND, 31'h2AAA_AAAA,      0,    0,    1'b0, RES_NONE);
        add_row(OP_QUERY,  '0,                 0,    1,    1'b0, RES_NONE);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_q[i]) begin
            @(negedge i_clk);
            pace_sender();
            drv_typed     = dir_q[i].typed;
            drv_typed_res = dir_q[i].res;
            send_req(dir_q[i].req);
        end
        run_items(MIX_NORMAL, 80);

        drain();
        write_bases('0, {CFG_DATA_W{1'b1}});
        run_items(MIX_NORMAL, 80);

        drain();
        write_bases(PRIME_A - 30'd1, PRIME_B);
        run_items(MIX_NORMAL, 80);

        // fill the store, then push against the full string
        drain();
        write_bases(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        while (sym_cnt < DEPTH) run_items(MIX_FILL, 1);
        run_items(MIX_FILL, 40);

        drain();
        write_bases(PRIME_A, PRIME_B - 30'd1);
        run_items(MIX_NORMAL, 100);

        drain();
        if (mismatch_cnt == 0) begin
            $display("prefix_rolling_hash_engine test passed");
        end else begin
            $display("prefix_rolling_hash_engine test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/phe_pkg.sv
rtl/phe_in_if.sv
rtl/phe_out_if.sv
rtl/phe_modmul.sv
rtl/phe_store.sv
rtl/prefix_rolling_hash_engine.sv
verif/prefix_rolling_hash_engine_tb.sv
